@@ rtl/hpdc_pkg.sv @@
// Shared constants, payload types and codes for the holonomic pose drive controller.
`timescale 1ns / 1ps
package hpdc_pkg;

    localparam int POS_W       = 16;
    localparam int SPEED_BASE  = 50;
    localparam int HEAD_W      = 9;
    localparam int ERR_W       = 8;
    localparam int SPD_W       = 8;
    localparam int DELTA_W     = 21;
    localparam int DELTA_SAT   = 1 << (DELTA_W - 1);
    localparam int SUM_W       = 2 * DELTA_W;
    localparam int RAD_W       = 22;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int MOT_W       = SPD_W + 2;
    localparam int FORCE_W     = 16;
    localparam int MAG_W       = FORCE_W - 1;
    localparam int PROD_W      = MAG_W + SPD_W;
    localparam int DIV_STEPS   = SPD_W;
    localparam int RECIP5      = 3277;
    localparam int RECIP5_SH   = 14;
    localparam int RECIP5_W    = 12;
    localparam int RECIP100    = 5243;
    localparam int RECIP100_SH = 19;
    localparam int RECIP100_W  = 13;
    localparam int QUE_DEPTH   = 4;
    localparam int QUE_AW      = $clog2(QUE_DEPTH);
    localparam int FRONT_LAT   = SQRT_STEPS + 5;
    localparam int CNT_LIM     = FRONT_LAT + QUE_DEPTH;
    localparam int CNT_W       = $clog2(CNT_LIM + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_DB  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_DB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_CAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_CAP = 3'd4;

    localparam logic [2:0] ACT_STOP    = 3'd0;
    localparam logic [2:0] ACT_FORWARD = 3'd1;
    localparam logic [2:0] ACT_ROT_CW  = 3'd2;
    localparam logic [2:0] ACT_ROT_CCW = 3'd3;
    localparam logic [2:0] ACT_ARC_CW  = 3'd4;
    localparam logic [2:0] ACT_ARC_CCW = 3'd5;

    typedef struct packed {
        logic signed [POS_W-1:0] cur_x;
        logic signed [POS_W-1:0] cur_y;
        logic [HEAD_W-1:0]       cur_heading;
        logic signed [POS_W-1:0] goal_x;
        logic signed [POS_W-1:0] goal_y;
        logic [HEAD_W-1:0]       goal_heading;
    } t_pose;

    typedef struct packed {
        logic             drive_enable;
        logic [SPD_W-1:0] duty_a;
        logic [SPD_W-1:0] duty_b;
        logic [SPD_W-1:0] duty_c;
        logic             dir_a;
        logic             dir_b;
        logic             dir_c;
        logic [2:0]       action;
    } t_drive;

    typedef struct packed {
        logic             mode;
        logic [7:0]       angle_db;
        logic [11:0]      dist_db;
        logic [SPD_W-1:0] rot_cap;
        logic [SPD_W-1:0] drv_cap;
    } t_cfg;

    typedef struct packed {
        logic                    enable;
        logic [2:0]              action;
        logic signed [MOT_W-1:0] x;
        logic signed [MOT_W-1:0] w;
        logic [SPD_W-1:0]        speed;
    } t_motion;

    typedef struct packed {
        logic empty;
        logic full;
    } t_que_stat;

endpackage

@@ rtl/hpdc_front.sv @@
// Front end: distance, square root and heading error pipeline that classifies each pose.
`timescale 1ns / 1ps
module hpdc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  hpdc_pkg::t_pose i_pose,
    input  hpdc_pkg::t_cfg  i_cfg,
    output logic           o_push,
    output hpdc_pkg::t_motion o_cmd
);
    import hpdc_pkg::*;

    localparam int M72_W  = 14;
    localparam int M111_W = 15;
    localparam int P72_W  = M72_W + RECIP100_W;
    localparam int P111_W = M111_W + RECIP100_W;
    localparam int QP_W   = ROOT_W + RECIP5_W;

    typedef struct packed {
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dy;
        logic [ERR_W-1:0]   r;
        logic               cw;
    } t_s2;

    typedef struct packed {
        logic [SUM_W-1:0]  sqx;
        logic [SUM_W-1:0]  sqy;
        logic [M72_W-1:0]  m72;
        logic [M111_W-1:0] m111;
        logic [23:0]       dd;
        logic [ERR_W-1:0]  r;
        logic              cw;
    } t_s3;

    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [RAD_W-1:0]  root;
        logic              sat;
        logic              moving;
        logic              cw;
        logic [ERR_W-1:0]  r;
        logic [P72_W-1:0]  p72;
        logic [P111_W-1:0] p111;
    } t_sq;

    typedef struct packed {
        logic [QP_W-1:0]   qprod;
        logic              sat;
        logic              moving;
        logic              cw;
        logic [ERR_W-1:0]  r;
        logic [P72_W-1:0]  p72;
        logic [P111_W-1:0] p111;
    } t_s16;

    function automatic logic [DELTA_W-1:0] sat_delta(input logic [POS_W:0] a);
        logic [32:0] e;
        e = 33'(a);
        return (e > 33'(DELTA_SAT)) ? DELTA_W'(DELTA_SAT) : e[DELTA_W-1:0];
    endfunction

    function automatic logic [HEAD_W-1:0] reduce(input logic [HEAD_W-1:0] h);
        return (h >= 9'd360) ? h - 9'd360 : h;
    endfunction

    function automatic t_sq sq_step(input t_sq d, input int k);
        t_sq              o;
        logic [RAD_W-1:0] b;
        logic [RAD_W-1:0] t;
        o = d;
        b = RAD_W'(1) << (RAD_W - 2 - 2 * k);
        t = d.root + b;
        if (d.rem >= t) begin
            o.rem  = d.rem - t;
            o.root = (d.root >> 1) + b;
        end else begin
            o.root = d.root >> 1;
        end
        return o;
    endfunction

    logic  r_v1, r_v2, r_v3, r_v4, r_v16;
    logic  r_vsq [SQRT_STEPS];
    t_pose r_in;
    t_s2   r_s2, n_s2;
    t_s3   r_s3, n_s3;
    t_sq   r_s4, n_s4;
    t_sq   r_sq [SQRT_STEPS];
    t_sq   n_sq [SQRT_STEPS];
    t_s16  r_s16, n_s16;

    logic signed [POS_W:0] dfx, dfy;
    logic [POS_W:0]        ax, ay;
    logic [HEAD_W-1:0]     ch, gh, e;
    logic [HEAD_W:0]       ediff;
    logic [SUM_W-1:0]      s;

    always_comb begin
        dfx   = (POS_W+1)'(r_in.goal_x) - (POS_W+1)'(r_in.cur_x);
        dfy   = (POS_W+1)'(r_in.goal_y) - (POS_W+1)'(r_in.cur_y);
        ax    = dfx[POS_W] ? (POS_W+1)'(-dfx) : dfx;
        ay    = dfy[POS_W] ? (POS_W+1)'(-dfy) : dfy;
        ch    = reduce(r_in.cur_heading);
        gh    = reduce(r_in.goal_heading);
        ediff = {1'b0, gh} + 10'd360 - {1'b0, ch};
        e     = (ediff >= 10'd360) ? HEAD_W'(ediff - 10'd360) : ediff[HEAD_W-1:0];
        n_s2.dx = sat_delta(ax);
        n_s2.dy = sat_delta(ay);
        n_s2.r  = (e > 9'd180) ? ERR_W'(9'd360 - e) : e[ERR_W-1:0];
        n_s2.cw = (e >= 9'd180);
    end

    always_comb begin
        n_s3.sqx  = SUM_W'(r_s2.dx) * SUM_W'(r_s2.dx);
        n_s3.sqy  = SUM_W'(r_s2.dy) * SUM_W'(r_s2.dy);
        n_s3.m72  = M72_W'(r_s2.r) * M72_W'(72);
        n_s3.m111 = M111_W'(r_s2.r) * M111_W'(111);
        n_s3.dd   = 24'(i_cfg.dist_db) * 24'(i_cfg.dist_db);
        n_s3.r    = r_s2.r;
        n_s3.cw   = r_s2.cw;
    end

    always_comb begin
        s           = r_s3.sqx + r_s3.sqy;
        n_s4.rem    = {s[RAD_W-3:0], 2'b00};
        n_s4.root   = '0;
        n_s4.sat    = |s[SUM_W-1:RAD_W-2];
        n_s4.moving = s > SUM_W'(r_s3.dd);
        n_s4.cw     = r_s3.cw;
        n_s4.r      = r_s3.r;
        n_s4.p72    = P72_W'(r_s3.m72) * P72_W'(RECIP100);
        n_s4.p111   = P111_W'(r_s3.m111) * P111_W'(RECIP100);
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        if (k == 0) begin : g_first
            always_comb n_sq[k] = sq_step(r_s4, k);
        end else begin : g_next
            always_comb n_sq[k] = sq_step(r_sq[k-1], k);
        end
    end

    always_comb begin
        n_s16.qprod  = QP_W'(r_sq[SQRT_STEPS-1].root[ROOT_W-1:0]) * QP_W'(RECIP5);
        n_s16.sat    = r_sq[SQRT_STEPS-1].sat;
        n_s16.moving = r_sq[SQRT_STEPS-1].moving;
        n_s16.cw     = r_sq[SQRT_STEPS-1].cw;
        n_s16.r      = r_sq[SQRT_STEPS-1].r;
        n_s16.p72    = r_sq[SQRT_STEPS-1].p72;
        n_s16.p111   = r_sq[SQRT_STEPS-1].p111;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v16 <= 1'b0;
            for (int k = 0; k < SQRT_STEPS; k++) r_vsq[k] <= 1'b0;
        end else begin
            r_v1     <= i_take;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_vsq[0] <= r_v4;
            for (int k = 1; k < SQRT_STEPS; k++) r_vsq[k] <= r_vsq[k-1];
            r_v16    <= r_vsq[SQRT_STEPS-1];
        end
        r_in  <= i_pose;
        r_s2  <= n_s2;
        r_s3  <= n_s3;
        r_s4  <= n_s4;
        for (int k = 0; k < SQRT_STEPS; k++) r_sq[k] <= n_sq[k];
        r_s16 <= n_s16;
    end

    logic [8:0]       q;
    logic [9:0]       usum, vsum, wsum;
    logic [SPD_W-1:0] u, v, w;

    always_comb begin
        q    = 9'(r_s16.qprod >> RECIP5_SH);
        usum = 10'(SPEED_BASE) + 10'(q);
        vsum = 10'(SPEED_BASE) + 10'(r_s16.p72 >> RECIP100_SH);
        wsum = 10'(SPEED_BASE) + 10'(r_s16.p111 >> RECIP100_SH);
        u = (r_s16.sat || usum > 10'(i_cfg.drv_cap)) ? i_cfg.drv_cap : usum[SPD_W-1:0];
        v = (vsum > 10'(i_cfg.rot_cap)) ? i_cfg.rot_cap : vsum[SPD_W-1:0];
        w = (wsum > 10'(i_cfg.drv_cap)) ? i_cfg.drv_cap : wsum[SPD_W-1:0];
        o_cmd = '0;
        priority if (i_cfg.mode) begin
            o_cmd.enable = 1'b1;
            o_cmd.x      = MOT_W'(u);
            o_cmd.w      = r_s16.cw ? MOT_W'(w) : -MOT_W'(w);
            o_cmd.speed  = u;
            o_cmd.action = r_s16.cw ? ACT_ARC_CW : ACT_ARC_CCW;
        end else if (r_s16.moving && r_s16.r > i_cfg.angle_db) begin
            o_cmd.enable = 1'b1;
            o_cmd.w      = r_s16.cw ? MOT_W'(1) : -MOT_W'(1);
            o_cmd.speed  = v;
            o_cmd.action = r_s16.cw ? ACT_ROT_CW : ACT_ROT_CCW;
        end else if (r_s16.moving) begin
            o_cmd.enable = 1'b1;
            o_cmd.x      = MOT_W'(1);
            o_cmd.speed  = u;
            o_cmd.action = ACT_FORWARD;
        end else begin
            o_cmd.action = ACT_STOP;
        end
    end

    assign o_push = r_v16;

endmodule

@@ rtl/hpdc_queue.sv @@
// Short command queue between the front end and the wheel mixer.
`timescale 1ns / 1ps
module hpdc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hpdc_pkg::t_motion   i_data,
    input  logic                i_pop,
    output hpdc_pkg::t_motion   o_data,
    output hpdc_pkg::t_que_stat o_stat
);
    import hpdc_pkg::*;

    t_motion           r_mem [QUE_DEPTH];
    logic [QUE_AW-1:0] r_wr, r_rd;
    logic [QUE_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QUE_AW+1)'(i_push) - (QUE_AW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (QUE_AW+1)'(QUE_DEPTH));

endmodule

@@ rtl/hpdc_back.sv @@
// Back end: wheel force mix, largest-wheel scaling by pipelined division, result register.
`timescale 1ns / 1ps
module hpdc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  hpdc_pkg::t_motion i_cmd,
    output logic              o_res_valid,
    output hpdc_pkg::t_drive  o_res
);
    import hpdc_pkg::*;

    typedef struct packed {
        logic signed [FORCE_W-1:0] f0, f1, f2;
        logic                      enable;
        logic [2:0]                action;
        logic [SPD_W-1:0]          speed;
    } t_b1;

    typedef struct packed {
        logic [MAG_W-1:0] a0, a1, a2;
        logic [2:0]       neg;
        logic [MAG_W-1:0] fmax;
        logic             enable;
        logic [2:0]       action;
        logic [SPD_W-1:0] speed;
    } t_b2;

    typedef struct packed {
        logic [PROD_W-1:0] rem0, rem1, rem2;
        logic [SPD_W-1:0]  q0, q1, q2;
        logic [MAG_W-1:0]  dvs;
        logic              zero;
        logic [2:0]        neg;
        logic              enable;
        logic [2:0]        action;
    } t_dv;

    function automatic logic [MAG_W-1:0] mag(input logic signed [FORCE_W-1:0] f);
        return f[FORCE_W-1] ? MAG_W'(-f) : f[MAG_W-1:0];
    endfunction

    function automatic t_dv dv_step(input t_dv d, input int k);
        t_dv               o;
        logic [PROD_W-1:0] sh;
        o  = d;
        sh = PROD_W'(d.dvs) << k;
        if (d.rem0 >= sh) begin
            o.rem0 = d.rem0 - sh;
            o.q0   = d.q0 | (SPD_W'(1) << k);
        end
        if (d.rem1 >= sh) begin
            o.rem1 = d.rem1 - sh;
            o.q1   = d.q1 | (SPD_W'(1) << k);
        end
        if (d.rem2 >= sh) begin
            o.rem2 = d.rem2 - sh;
            o.q2   = d.q2 | (SPD_W'(1) << k);
        end
        return o;
    endfunction

    logic r_v1, r_v2, r_v3;
    logic r_vdv [DIV_STEPS];
    t_b1  r_b1, n_b1;
    t_b2  r_b2, n_b2;
    t_dv  r_b3, n_b3;
    t_dv  r_dv [DIV_STEPS];
    t_dv  n_dv [DIV_STEPS];
    t_drive n_res;

    logic signed [FORCE_W-1:0] xe, we;
    logic [MAG_W-1:0]          m01;

    always_comb begin
        xe = FORCE_W'(i_cmd.x);
        we = FORCE_W'(i_cmd.w);
        n_b1.f0     = FORCE_W'(58) * xe + FORCE_W'(33) * we;
        n_b1.f1     = FORCE_W'(33) * we - FORCE_W'(58) * xe;
        n_b1.f2     = FORCE_W'(33) * we;
        n_b1.enable = i_cmd.enable;
        n_b1.action = i_cmd.action;
        n_b1.speed  = i_cmd.speed;
    end

    always_comb begin
        n_b2.a0     = mag(r_b1.f0);
        n_b2.a1     = mag(r_b1.f1);
        n_b2.a2     = mag(r_b1.f2);
        n_b2.neg    = {r_b1.f2[FORCE_W-1], r_b1.f1[FORCE_W-1], r_b1.f0[FORCE_W-1]};
        m01         = (n_b2.a0 > n_b2.a1) ? n_b2.a0 : n_b2.a1;
        n_b2.fmax   = (m01 > n_b2.a2) ? m01 : n_b2.a2;
        n_b2.enable = r_b1.enable;
        n_b2.action = r_b1.action;
        n_b2.speed  = r_b1.speed;
    end

    always_comb begin
        n_b3.rem0   = PROD_W'(r_b2.a0) * PROD_W'(r_b2.speed);
        n_b3.rem1   = PROD_W'(r_b2.a1) * PROD_W'(r_b2.speed);
        n_b3.rem2   = PROD_W'(r_b2.a2) * PROD_W'(r_b2.speed);
        n_b3.q0     = '0;
        n_b3.q1     = '0;
        n_b3.q2     = '0;
        n_b3.dvs    = r_b2.fmax;
        n_b3.zero   = (r_b2.fmax == '0);
        n_b3.neg    = r_b2.neg;
        n_b3.enable = r_b2.enable;
        n_b3.action = r_b2.action;
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        if (j == 0) begin : g_first
            always_comb n_dv[j] = dv_step(r_b3, DIV_STEPS - 1 - j);
        end else begin : g_next
            always_comb n_dv[j] = dv_step(r_dv[j-1], DIV_STEPS - 1 - j);
        end
    end

    always_comb begin
        n_res.drive_enable = r_dv[DIV_STEPS-1].enable;
        n_res.action       = r_dv[DIV_STEPS-1].action;
        if (!r_dv[DIV_STEPS-1].enable) begin
            n_res.duty_a = '1;
            n_res.duty_b = '1;
            n_res.duty_c = '1;
            n_res.dir_a  = 1'b1;
            n_res.dir_b  = 1'b1;
            n_res.dir_c  = 1'b1;
        end else begin
            n_res.duty_a = r_dv[DIV_STEPS-1].zero ? '0 : r_dv[DIV_STEPS-1].q0;
            n_res.duty_b = r_dv[DIV_STEPS-1].zero ? '0 : r_dv[DIV_STEPS-1].q1;
            n_res.duty_c = r_dv[DIV_STEPS-1].zero ? '0 : r_dv[DIV_STEPS-1].q2;
            n_res.dir_a  = r_dv[DIV_STEPS-1].neg[0];
            n_res.dir_b  = r_dv[DIV_STEPS-1].neg[1];
            n_res.dir_c  = r_dv[DIV_STEPS-1].neg[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            o_res_valid <= 1'b0;
            for (int j = 0; j < DIV_STEPS; j++) r_vdv[j] <= 1'b0;
        end else begin
            r_v1     <= i_take;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_vdv[0] <= r_v3;
            for (int j = 1; j < DIV_STEPS; j++) r_vdv[j] <= r_vdv[j-1];
            o_res_valid <= r_vdv[DIV_STEPS-1];
        end
        r_b1 <= n_b1;
        r_b2 <= n_b2;
        r_b3 <= n_b3;
        for (int j = 0; j < DIV_STEPS; j++) r_dv[j] <= n_dv[j];
        o_res <= n_res;
    end

endmodule

@@ rtl/holonomic_pose_drive_controller.sv @@
// Top level: configuration registers, credit control, front end, queue and wheel mixer.
//
//  port group              dir   handshake                 payload
//  start / busy / i_pose   in    start && !busy            t_pose
//  o_res_valid / o_res     out   one-cycle strobe          t_drive
//  i_cfg_* / o_cfg_ready   in    i_cfg_valid && ready      index, data
//
//  Takes one pose per cycle while busy is low; each result strobes once its start
//  has passed the front end (11-step square root), the queue and the mixer
//  (8-step divider).
//  Synchronous active-low reset clears pipeline valids, queue pointers and credit count, and loads config defaults.
//  busy rises only when the credit count of items in flight reaches its limit,
//  which full-rate input never reaches; results cannot be held off.
`timescale 1ns / 1ps
module holonomic_pose_drive_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  hpdc_pkg::t_pose                    i_pose,
    output logic                               busy,
    output logic                               o_res_valid,
    output hpdc_pkg::t_drive                   o_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hpdc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hpdc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hpdc_pkg::*;

    t_cfg             r_cfg;
    logic [CNT_W-1:0] r_cnt;
    logic             take, que_push, que_pop;
    t_motion          push_cmd, head_cmd;
    t_que_stat        que_stat;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_cnt == CNT_W'(CNT_LIM));
    assign take        = start && !busy;
    assign que_pop     = !que_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= 1'b0;
            r_cfg.angle_db <= 8'd10;
            r_cfg.dist_db  <= 12'd100;
            r_cfg.rot_cap  <= 8'd150;
            r_cfg.drv_cap  <= 8'd250;
            r_cnt          <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_idx)
                    CFG_MODE:      r_cfg.mode     <= i_cfg_data[0];
                    CFG_ANGLE_DB:  r_cfg.angle_db <= i_cfg_data[7:0];
                    CFG_DIST_DB:   r_cfg.dist_db  <= i_cfg_data[11:0];
                    CFG_ROT_CAP:   r_cfg.rot_cap  <= i_cfg_data[7:0];
                    CFG_DRIVE_CAP: r_cfg.drv_cap  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_cnt <= r_cnt + CNT_W'(take) - CNT_W'(que_pop);
        end
    end

    hpdc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_pose  (i_pose),
        .i_cfg   (r_cfg),
        .o_push  (que_push),
        .o_cmd   (push_cmd)
    );

    hpdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (que_push),
        .i_data  (push_cmd),
        .i_pop   (que_pop),
        .o_data  (head_cmd),
        .o_stat  (que_stat)
    );

    hpdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (que_pop),
        .i_cmd       (head_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    a_que_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        que_push |-> !que_stat.full)
        else $error("command queue overflow");

    a_halt_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.drive_enable |->
            o_res.duty_a == 8'hFF && o_res.duty_b == 8'hFF && o_res.duty_c == 8'hFF &&
            o_res.dir_a && o_res.dir_b && o_res.dir_c && o_res.action == ACT_STOP)
        else $error("halted result with wrong drive pattern");

    a_forward_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.drive_enable && o_res.action == ACT_FORWARD |->
            o_res.duty_c == 8'd0 && !o_res.dir_a && o_res.dir_b && !o_res.dir_c)
        else $error("forward result with wrong wheel pattern");

    a_credit_covers_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !que_stat.empty |-> r_cnt != '0)
        else $error("queued command without credit");

endmodule
